>>> hdl/ptk_pkg.sv
// Shared constants, types and records of the path component tokenizer.
`default_nettype none
package ptk_pkg;

    localparam int MAX_PATH_BYTES = 255;
    localparam int MAX_NAME_BYTES = 63;
    localparam int MAX_DEPTH      = 32;
    localparam int MAX_COMPONENTS = (MAX_PATH_BYTES + 1) / 2;

    // Output field widths
    localparam int CH_W     = 8;
    localparam int START_W  = 8;
    localparam int OLEN_W   = 6;
    localparam int OCNT_W   = 8;
    localparam int ODEPTH_W = 6;

    // Internal counter widths, never narrower than the field they feed
    localparam int POS_BITS = $clog2(MAX_PATH_BYTES + 1);
    localparam int POS_W    = (POS_BITS > START_W) ? POS_BITS : START_W;
    localparam int LEN_BITS = $clog2(MAX_NAME_BYTES + 2);
    localparam int LEN_W    = (LEN_BITS > OLEN_W) ? LEN_BITS : OLEN_W;
    localparam int LVL_BITS = $clog2(MAX_DEPTH + 1);
    localparam int LVL_W    = (LVL_BITS > ODEPTH_W) ? LVL_BITS : ODEPTH_W;
    localparam int CNT_BITS = $clog2(MAX_COMPONENTS + 1);
    localparam int CNT_W    = (CNT_BITS > OCNT_W) ? CNT_BITS : OCNT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CH_W-1:0] CH_TERM  = 8'h00;
    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_NAME_LONG = 3'd3,
        ST_TOO_DEEP  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CT_NORMAL = 2'd0,
        CT_DOT    = 2'd1,
        CT_DOTDOT = 2'd2
    } t_ctype;

    typedef enum logic {
        KIND_COMP    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    // Work handed from the front end to the back end
    typedef struct packed {
        logic               do_close;
        logic               do_end;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               dots;
        logic               overlong;
        logic               empty;
        logic               trail;
    } t_token;

    typedef struct packed {
        t_kind                item_kind;
        logic [START_W-1:0]   comp_start;
        logic [OLEN_W-1:0]    comp_length;
        t_ctype               comp_type;
        t_status              status;
        logic [OCNT_W-1:0]    comp_count;
        logic [ODEPTH_W-1:0]  final_depth;
        logic                 trailing_slash;
        logic                 last_item;
    } t_out_rec;

endpackage
`default_nettype wire

>>> hdl/ptk_if.sv
// Stream interfaces for path bytes in and tokenizer records out.
`default_nettype none
interface ptk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface ptk_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] comp_start;
    logic [5:0] comp_length;
    logic [1:0] comp_type;
    logic [2:0] status;
    logic [7:0] comp_count;
    logic [5:0] final_depth;
    logic       trailing_slash;
    logic       last_item;

    modport source (
        output valid, input ready,
        output item_kind, output comp_start, output comp_length, output comp_type,
        output status, output comp_count, output final_depth,
        output trailing_slash, output last_item
    );
    modport sink (
        input valid, output ready,
        input item_kind, input comp_start, input comp_length, input comp_type,
        input status, input comp_count, input final_depth,
        input trailing_slash, input last_item
    );
endinterface
`default_nettype wire

>>> hdl/path_component_tokenizer_top.sv
// Top level of the path component tokenizer.
// Takes a path one byte per cycle, ended by a zero byte, and gives one component record
// for each finished name between '/' runs (start offset, length, normal/dot/dotdot) while
// the path is still error free, then a summary record with status, count, depth and the
// trailing-separator flag. The front end accepts one byte every cycle and stalls only when
// its four-entry token queue is full; the back end retires one token per cycle into a
// registered output stage while that stage is empty or being read, except that a
// terminator which closes an open name gives its record first and then the summary. A
// record is valid only after its token has been queued and then registered at the output.
`default_nettype none
module path_component_tokenizer_top
    import ptk_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ptk_in_if.sink    i_in,
    ptk_out_if.source o_out
);

    logic   push;
    t_token push_data;
    logic   full;
    logic   tok_valid;
    t_token tok;
    logic   pop;

    ptk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    ptk_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_pop_valid (tok_valid),
        .o_pop_data  (tok),
        .i_pop       (pop)
    );

    ptk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

>>> hdl/ptk_queue.sv
// Small token queue between the byte front end and the record back end.
`default_nettype none
module ptk_queue
    import ptk_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_token i_push_data,
    output logic        o_full,
    output logic        o_pop_valid,
    output t_token      o_pop_data,
    input  wire logic   i_pop
);

    t_token              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_data  = r_mem[r_rd];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hdl/ptk_front.sv
// Byte front end: tracks position and the open component, queues close and end work.
`default_nettype none
module ptk_front
    import ptk_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ptk_in_if.sink    i_in,
    input  wire logic i_full,
    output logic      o_push,
    output t_token    o_push_data
);

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [START_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic               r_dots,  n_dots;
    logic               r_prev_slash, n_prev_slash;
    logic               r_overlong,   n_overlong;

    logic acc;
    logic is_term;
    logic is_slash;
    logic is_dot;
    logic over;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;
    assign is_term    = (i_in.ch == CH_TERM);
    assign is_slash   = (i_in.ch == CH_SLASH);
    assign is_dot     = (i_in.ch == CH_DOT);
    assign over       = (r_pos >= POS_W'(MAX_PATH_BYTES));

    always_comb begin
        n_pos        = r_pos;
        n_start      = r_start;
        n_len        = r_len;
        n_dots       = r_dots;
        n_prev_slash = r_prev_slash;
        n_overlong   = r_overlong;
        o_push       = 1'b0;
        o_push_data.do_close = 1'b0;
        o_push_data.do_end   = 1'b0;
        o_push_data.start    = r_start;
        o_push_data.len      = r_len;
        o_push_data.dots     = r_dots;
        o_push_data.overlong = r_overlong;
        o_push_data.empty    = (r_pos == '0);
        o_push_data.trail    = r_prev_slash;
        if (acc) begin
            if (is_term) begin
                // an open component is dropped once the path is overlong
                o_push               = 1'b1;
                o_push_data.do_close = (r_len != '0) && !r_overlong;
                o_push_data.do_end   = 1'b1;
                n_pos        = '0;
                n_start      = '0;
                n_len        = '0;
                n_dots       = 1'b1;
                n_prev_slash = 1'b0;
                n_overlong   = 1'b0;
            end else begin
                if (over) begin
                    n_overlong = 1'b1;
                end else begin
                    if (is_slash) begin
                        if (r_len != '0) begin
                            o_push               = 1'b1;
                            o_push_data.do_close = 1'b1;
                        end
                        n_len = '0;
                    end else begin
                        if (r_len == '0) begin
                            n_start = r_pos[START_W-1:0];
                            n_dots  = 1'b1;
                        end
                        // saturate one past the name limit
                        if (r_len <= LEN_W'(MAX_NAME_BYTES)) begin
                            n_len = r_len + 1'b1;
                        end
                        if (!is_dot) begin
                            n_dots = 1'b0;
                        end
                    end
                    n_pos = r_pos + 1'b1;
                end
                n_prev_slash = is_slash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_start      <= '0;
            r_len        <= '0;
            r_dots       <= 1'b1;
            r_prev_slash <= 1'b0;
            r_overlong   <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_start      <= n_start;
            r_len        <= n_len;
            r_dots       <= n_dots;
            r_prev_slash <= n_prev_slash;
            r_overlong   <= n_overlong;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ptk_back.sv
// Record back end: classifies components, keeps depth, count and first error, drives records.
`default_nettype none
module ptk_back
    import ptk_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_tok_valid,
    input  wire t_token i_tok,
    output logic        o_pop,
    ptk_out_if.source   o_out
);

    logic [LVL_W-1:0] r_level, n_level;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_err,   n_err;
    logic             r_closed, n_closed;
    logic             r_out_valid, n_out_valid;
    t_out_rec         r_out, n_out;

    t_ctype           ctype;
    logic             step;
    logic             phase_close;
    logic             c_rec;
    t_status          c_err;
    logic [LVL_W-1:0] c_level;

    assign step        = i_tok_valid && (!r_out_valid || o_out.ready);
    assign phase_close = i_tok.do_close && !r_closed;

    always_comb begin
        if (i_tok.dots && (i_tok.len == LEN_W'(2))) begin
            ctype = CT_DOTDOT;
        end else if (i_tok.dots && (i_tok.len == LEN_W'(1))) begin
            ctype = CT_DOT;
        end else begin
            ctype = CT_NORMAL;
        end
    end

    // Component checks in priority order; the first error sticks
    always_comb begin
        c_rec   = 1'b0;
        c_err   = r_err;
        c_level = r_level;
        if (r_err != ST_OK) begin
            c_rec = 1'b0;
        end else if (i_tok.len > LEN_W'(MAX_NAME_BYTES)) begin
            c_err = ST_NAME_LONG;
        end else if ((ctype == CT_DOTDOT) && (r_level == '0)) begin
            c_err = ST_INVALID;
        end else if ((ctype == CT_NORMAL) && (r_level >= LVL_W'(MAX_DEPTH))) begin
            c_err = ST_TOO_DEEP;
        end else if (r_count >= CNT_W'(MAX_COMPONENTS)) begin
            c_err = ST_TOO_DEEP;
        end else begin
            c_rec = 1'b1;
            if (ctype == CT_DOTDOT) begin
                c_level = r_level - 1'b1;
            end else if (ctype == CT_NORMAL) begin
                c_level = r_level + 1'b1;
            end
        end
    end

    always_comb begin
        n_level     = r_level;
        n_count     = r_count;
        n_err       = r_err;
        n_closed    = r_closed;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        o_pop       = 1'b0;
        if (step) begin
            if (phase_close) begin
                n_err   = c_err;
                n_level = c_level;
                if (c_rec) begin
                    n_count = r_count + 1'b1;
                end
                n_out_valid           = c_rec;
                n_out.item_kind       = KIND_COMP;
                n_out.comp_start      = i_tok.start;
                n_out.comp_length     = i_tok.len[OLEN_W-1:0];
                n_out.comp_type       = ctype;
                n_out.status          = ST_OK;
                n_out.comp_count      = n_count[OCNT_W-1:0];
                n_out.final_depth     = c_level[ODEPTH_W-1:0];
                n_out.trailing_slash  = 1'b0;
                n_out.last_item       = 1'b0;
                // hold an end token for its summary on the next step
                if (i_tok.do_end) begin
                    n_closed = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_out_valid           = 1'b1;
                n_out.item_kind       = KIND_SUMMARY;
                n_out.comp_start      = '0;
                n_out.comp_length     = '0;
                n_out.comp_type       = CT_NORMAL;
                if (i_tok.overlong) begin
                    n_out.status = ST_TOO_LONG;
                end else if (i_tok.empty) begin
                    n_out.status = ST_INVALID;
                end else begin
                    n_out.status = r_err;
                end
                n_out.comp_count      = r_count[OCNT_W-1:0];
                n_out.final_depth     = r_level[ODEPTH_W-1:0];
                n_out.trailing_slash  = i_tok.trail;
                n_out.last_item       = 1'b1;
                n_level  = '0;
                n_count  = '0;
                n_err    = ST_OK;
                n_closed = 1'b0;
                o_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_level     <= n_level;
            r_count     <= n_count;
            r_err       <= n_err;
            r_closed    <= n_closed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.item_kind       = r_out.item_kind;
    assign o_out.comp_start      = r_out.comp_start;
    assign o_out.comp_length     = r_out.comp_length;
    assign o_out.comp_type       = r_out.comp_type;
    assign o_out.status          = r_out.status;
    assign o_out.comp_count      = r_out.comp_count;
    assign o_out.final_depth     = r_out.final_depth;
    assign o_out.trailing_slash  = r_out.trailing_slash;
    assign o_out.last_item       = r_out.last_item;

endmodule
`default_nettype wire
